@@ rtl/core/prlm_pkg.sv @@
// Shared types and constants of the particle ring lifetime manager.
// No dependencies; imported by particle_ring_lifetime_manager.
package prlm_pkg;

	localparam int TIME_W      = 32;
	localparam int ACC_W       = TIME_W + 1;
	localparam int COUNT_OUT_W = 9;
	localparam int SLOT_OUT_W  = 8;
	localparam int CFG_INDEX_W = 4;

	localparam int DIV_STEPS = ACC_W;
	localparam int DIV_CNT_W = 6;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPAWN_INTERVAL    = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_PARTICLE_LIFETIME = CFG_INDEX_W'(1);

	localparam logic [TIME_W-1:0] SPAWN_INTERVAL_RST    = TIME_W'(6554);
	localparam logic [TIME_W-1:0] PARTICLE_LIFETIME_RST = TIME_W'(65536);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RETIRE,
		ST_DIVIDE,
		ST_CLAMP,
		ST_SPAWN,
		ST_FINISH
	} prlm_state_t;

endpackage

@@ rtl/core/prlm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the spawn stamps of the particle ring.
module prlm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/particle_ring_lifetime_manager.sv @@
// Per tick: walk the live stamps through the single memory read port, run the
// bit-serial divider when the accumulated time exceeds the spawn interval, clamp
// the spawns to the free room, write one stamp per spawn, then load the result.
// One tick at a time: in_stall is high from acceptance until the result is loaded.
// Reset clears pointers, counts, accumulator and restores the configuration
// defaults; the stamp memory is not cleared.
module particle_ring_lifetime_manager #(
	parameter int SLOT_COUNT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [prlm_pkg::TIME_W-1:0]      delta_time,
	input  logic [prlm_pkg::TIME_W-1:0]      now_time,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [prlm_pkg::COUNT_OUT_W-1:0] retired_count,
	output logic [prlm_pkg::COUNT_OUT_W-1:0] spawned_count,
	output logic [prlm_pkg::COUNT_OUT_W-1:0] live_total,
	output logic [prlm_pkg::SLOT_OUT_W-1:0]  head_slot,
	output logic [prlm_pkg::SLOT_OUT_W-1:0]  tail_slot,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [prlm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [prlm_pkg::TIME_W-1:0]      cfg_data
);

	import prlm_pkg::*;

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int SW = CW + 1;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] slot);
		ring_next = (slot == IW'(SLOT_COUNT - 1)) ? '0 : slot + IW'(1);
	endfunction

	prlm_state_t state_q, state_d;

	logic [TIME_W-1:0]    spawn_interval_q;
	logic [TIME_W-1:0]    lifetime_q;
	logic [TIME_W-1:0]    emit_q;
	logic [CW-1:0]        live_q;
	logic [IW-1:0]        head_q;
	logic [IW-1:0]        tail_q;
	logic [TIME_W-1:0]    delta_q;
	logic [TIME_W-1:0]    now_q;
	logic [CW-1:0]        issue_cnt_q;
	logic [IW-1:0]        rd_slot_q;
	logic                 rd_pend_s1;
	logic [CW-1:0]        retired_q;
	logic [CW-1:0]        spawned_q;
	logic [CW-1:0]        spawn_left_q;
	logic [ACC_W-1:0]     dvd_q;
	logic [ACC_W-1:0]     quot_q;
	logic [TIME_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic                 in_accept;
	logic                 out_free;
	logic                 retire_done;
	logic                 div_last;
	logic [TIME_W-1:0]    interval;
	logic [ACC_W-1:0]     acc_sum;
	logic                 need_div;
	logic [ACC_W-1:0]     rem_shift;
	logic                 div_ge;
	logic [TIME_W-1:0]    rem_next;
	logic [TIME_W-1:0]    age;
	logic [SW-1:0]        head_sum;
	logic [SW-1:0]        head_wrap;
	logic [CW-1:0]        room;
	logic [CW-1:0]        spawn_take;

	logic                 ram_we;
	logic                 ram_re;
	logic [TIME_W-1:0]    ram_rdata;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	assign retire_done = (issue_cnt_q == live_q) && !rd_pend_s1;
	assign div_last    = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	assign interval = (spawn_interval_q == '0) ? TIME_W'(1) : spawn_interval_q;
	assign acc_sum  = {1'b0, emit_q} + {1'b0, delta_q};
	assign need_div = acc_sum > {1'b0, interval};

	assign rem_shift = {rem_q, dvd_q[ACC_W-1]};
	assign div_ge    = rem_shift >= {1'b0, interval};
	assign rem_next  = div_ge ? TIME_W'(rem_shift - {1'b0, interval}) : rem_shift[TIME_W-1:0];

	assign age = now_q - ram_rdata;

	assign head_sum  = SW'(head_q) + SW'(retired_q);
	assign head_wrap = (head_sum >= SW'(SLOT_COUNT)) ? head_sum - SW'(SLOT_COUNT) : head_sum;

	assign room       = CW'(SLOT_COUNT) - live_q;
	assign spawn_take = (quot_q > ACC_W'(room)) ? room : quot_q[CW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RETIRE;
				end
			end
			ST_RETIRE: begin
				if (retire_done) begin
					state_d = need_div ? ST_DIVIDE : ST_SPAWN;
				end
			end
			ST_DIVIDE: begin
				if (div_last) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				state_d = ST_SPAWN;
			end
			ST_SPAWN: begin
				if (spawn_left_q == '0) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_RETIRE: begin
				ram_re = (issue_cnt_q != live_q);
			end
			ST_SPAWN: begin
				ram_we = (spawn_left_q != '0);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			spawn_interval_q <= SPAWN_INTERVAL_RST;
			lifetime_q       <= PARTICLE_LIFETIME_RST;
			emit_q           <= '0;
			live_q           <= '0;
			head_q           <= '0;
			tail_q           <= '0;
			issue_cnt_q      <= '0;
			rd_pend_s1       <= 1'b0;
			retired_q        <= '0;
			spawned_q        <= '0;
			spawn_left_q     <= '0;
			div_cnt_q        <= '0;
			out_valid        <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= ram_re;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SPAWN_INTERVAL:    spawn_interval_q <= cfg_data;
					CFG_PARTICLE_LIFETIME: lifetime_q       <= cfg_data;
					default:               ;
				endcase
			end

			if (in_accept) begin
				issue_cnt_q  <= '0;
				retired_q    <= '0;
				spawned_q    <= '0;
				spawn_left_q <= '0;
			end

			if (ram_re) begin
				issue_cnt_q <= issue_cnt_q + CW'(1);
			end
			if (rd_pend_s1 && (age >= lifetime_q)) begin
				retired_q <= retired_q + CW'(1);
			end

			if (state_q == ST_RETIRE && retire_done) begin
				head_q    <= IW'(head_wrap);
				live_q    <= live_q - retired_q;
				div_cnt_q <= '0;
				if (!need_div) begin
					emit_q <= acc_sum[TIME_W-1:0];
				end
			end

			if (state_q == ST_DIVIDE) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end

			if (state_q == ST_CLAMP) begin
				emit_q       <= rem_q + TIME_W'(1);
				spawn_left_q <= spawn_take;
			end

			if (ram_we) begin
				tail_q       <= ring_next(tail_q);
				spawn_left_q <= spawn_left_q - CW'(1);
				spawned_q    <= spawned_q + CW'(1);
				live_q       <= live_q + CW'(1);
			end

			if (state_q == ST_FINISH && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			delta_q   <= delta_time;
			now_q     <= now_time;
			rd_slot_q <= head_q;
		end
		if (ram_re) begin
			rd_slot_q <= ring_next(rd_slot_q);
		end
		if (state_q == ST_RETIRE && retire_done) begin
			dvd_q  <= acc_sum - ACC_W'(1);
			quot_q <= '0;
			rem_q  <= '0;
		end
		if (state_q == ST_DIVIDE) begin
			dvd_q  <= {dvd_q[ACC_W-2:0], 1'b0};
			quot_q <= {quot_q[ACC_W-2:0], div_ge};
			rem_q  <= rem_next;
		end
		if (state_q == ST_FINISH && out_free) begin
			retired_count <= COUNT_OUT_W'(retired_q);
			spawned_count <= COUNT_OUT_W'(spawned_q);
			live_total    <= COUNT_OUT_W'(live_q);
			head_slot     <= SLOT_OUT_W'(head_q);
			tail_slot     <= SLOT_OUT_W'(tail_q);
		end
	end

	prlm_ram #(
		.WIDTH (TIME_W),
		.DEPTH (SLOT_COUNT)
	) u_stamp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (now_q),
		.re    (ram_re),
		.raddr (rd_slot_q),
		.rdata (ram_rdata)
	);

endmodule

@@ dv/tb_particle_ring_lifetime_manager.sv @@
// Self-checking testbench for particle_ring_lifetime_manager: directed ticks, then random
// ticks under several spawn and lifetime settings, checked against an in-bench ring model.
// Depends on prlm_pkg and the particle_ring_lifetime_manager RTL.
module tb_particle_ring_lifetime_manager;
	timeunit 1ns;
	timeprecision 1ps;

	import prlm_pkg::*;

	localparam int SLOTS = 256;
	localparam int PHASE_TICKS = 68;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = CFG_PARTICLE_LIFETIME + 1'b1;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = '1;

	typedef struct packed {
		logic [COUNT_OUT_W-1:0] retired;
		logic [COUNT_OUT_W-1:0] spawned;
		logic [COUNT_OUT_W-1:0] live;
		logic [SLOT_OUT_W-1:0]  head;
		logic [SLOT_OUT_W-1:0]  tail;
	} tick_result_t;

	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		logic [TIME_W-1:0]      data;
		logic [TIME_W-1:0]      delta;
		logic [TIME_W-1:0]      now;
		bit                     typed;
		tick_result_t           res;
	} step_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [TIME_W-1:0]      delta_time;
	logic [TIME_W-1:0]      now_time;
	logic                   out_valid;
	logic                   out_stall;
	logic [COUNT_OUT_W-1:0] retired_count;
	logic [COUNT_OUT_W-1:0] spawned_count;
	logic [COUNT_OUT_W-1:0] live_total;
	logic [SLOT_OUT_W-1:0]  head_slot;
	logic [SLOT_OUT_W-1:0]  tail_slot;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [TIME_W-1:0]      cfg_data;

	logic [TIME_W-1:0]     stamp_mem [0:SLOTS-1];
	logic [TIME_W-1:0]     emit_acc;
	int unsigned           live_n;
	logic [SLOT_OUT_W-1:0] head_ix;
	logic [SLOT_OUT_W-1:0] tail_ix;
	logic [TIME_W-1:0]     cur_interval;
	logic [TIME_W-1:0]     cur_lifetime;

	tick_result_t pending_ticks [$];
	step_row_t    steps [$];
	int           fault_count;
	bit           gaps_on;
	bit           stall_on;

	particle_ring_lifetime_manager #(.SLOT_COUNT(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.delta_time(delta_time),
		.now_time(now_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.retired_count(retired_count),
		.spawned_count(spawned_count),
		.live_total(live_total),
		.head_slot(head_slot),
		.tail_slot(tail_slot),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic tick_result_t ring_predict(input logic [TIME_W-1:0] d,
			input logic [TIME_W-1:0] n);
		tick_result_t          r;
		logic [SLOT_OUT_W-1:0] slot;
		logic [TIME_W-1:0]     age;
		int unsigned           gone;
		int unsigned           born;
		int unsigned           room;
		logic [63:0]           sum;
		logic [63:0]           intv;
		logic [63:0]           ticks;
		gone = 0;
		slot = head_ix;
		for (int i = 0; i < live_n; i++) begin
			age = n - stamp_mem[slot];
			if (age >= cur_lifetime)
				gone++;
			slot++;
		end
		head_ix = head_ix + SLOT_OUT_W'(gone);
		live_n = live_n - gone;

		intv = (cur_interval == '0) ? 64'd1 : 64'(cur_interval);
		sum = 64'(emit_acc) + 64'(d);
		ticks = (sum > intv) ? (sum - 64'd1) / intv : 64'd0;
		sum = sum - ticks * intv;
		emit_acc = sum[TIME_W-1:0];

		room = SLOTS - live_n;
		born = (ticks < 64'(room)) ? int'(ticks) : room;
		for (int i = 0; i < born; i++) begin
			stamp_mem[tail_ix] = n;
			tail_ix++;
		end
		live_n = live_n + born;

		r.retired = COUNT_OUT_W'(gone);
		r.spawned = COUNT_OUT_W'(born);
		r.live = COUNT_OUT_W'(live_n);
		r.head = head_ix;
		r.tail = tail_ix;
		return r;
	endfunction

	function automatic step_row_t tick_row(input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] n);
		step_row_t row;
		row = '{default: '0};
		row.delta = d;
		row.now = n;
		return row;
	endfunction

	function automatic step_row_t typed_row(input logic [TIME_W-1:0] d,
			input logic [TIME_W-1:0] n, input int r, input int s, input int l,
			input int h, input int t);
		step_row_t row;
		row = tick_row(d, n);
		row.typed = 1'b1;
		row.res = '{COUNT_OUT_W'(r), COUNT_OUT_W'(s), COUNT_OUT_W'(l), SLOT_OUT_W'(h),
			SLOT_OUT_W'(t)};
		return row;
	endfunction

	function automatic step_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [TIME_W-1:0] data);
		step_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	task automatic idle_input(input int cycles);
		repeat (cycles) @(negedge clk) in_valid <= 1'b0;
	endtask

	task automatic drain_ring();
		idle_input(1);
		while (pending_ticks.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_tick(input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] n,
			input bit typed, input tick_result_t typed_res);
		tick_result_t r;
		@(negedge clk);
		in_valid <= 1'b1;
		delta_time <= d;
		now_time <= n;
		do @(posedge clk); while (in_stall);
		r = ring_predict(d, n);
		pending_ticks.push_back(typed ? typed_res : r);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TIME_W-1:0] data);
		drain_ring();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SPAWN_INTERVAL:    cur_interval = data;
			CFG_PARTICLE_LIFETIME: cur_lifetime = data;
			default: ;
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [COUNT_OUT_W-1:0] want,
			input logic [COUNT_OUT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ticks.size() == 0) begin
				$error("result transaction with no tick outstanding");
				fault_count++;
			end else begin
				want = pending_ticks.pop_front();
				check_field("retired_count", want.retired, retired_count);
				check_field("spawned_count", want.spawned, spawned_count);
				check_field("live_total", want.live, live_total);
				check_field("head_slot", COUNT_OUT_W'(want.head), COUNT_OUT_W'(head_slot));
				check_field("tail_slot", COUNT_OUT_W'(want.tail), COUNT_OUT_W'(tail_slot));
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_on) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
				@(negedge clk) out_stall <= 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end else begin
				@(negedge clk) out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [TIME_W-1:0] iv;
		logic [TIME_W-1:0] lt;
		logic [TIME_W-1:0] d;
		logic [TIME_W-1:0] clock_now;
		logic [63:0]       step;
		logic [63:0]       wide;
		int                sel;

		arst_n = 1'b0;
		in_valid = 1'b0;
		delta_time = '0;
		now_time = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fault_count = 0;
		gaps_on = 1'b1;
		stall_on = 1'b1;
		emit_acc = '0;
		live_n = 0;
		head_ix = '0;
		tail_ix = '0;
		cur_interval = SPAWN_INTERVAL_RST;
		cur_lifetime = PARTICLE_LIFETIME_RST;
		foreach (stamp_mem[i])
			stamp_mem[i] = '0;
		clock_now = '0;

		steps.push_back(typed_row(32'h0, 32'h0, 0, 0, 0, 0, 0));
		steps.push_back(typed_row(32'd19662, 32'h0, 0, 2, 2, 0, 2));
		steps.push_back(typed_row(32'd1, 32'h0000_FFFF, 0, 1, 3, 0, 3));
		steps.push_back(typed_row(32'h0, 32'h0001_0000, 2, 0, 1, 2, 3));
		steps.push_back(typed_row(32'hFFFF_FFFF, 32'h0001_0000, 0, 255, 256, 2, 2));
		steps.push_back(typed_row(32'hFFFF_FFFF, 32'h0001_0000, 0, 0, 256, 2, 2));
		steps.push_back(typed_row(32'h0, 32'h0001_FFFF, 1, 0, 255, 3, 2));
		steps.push_back(typed_row(32'h0, 32'h0002_0000, 255, 0, 0, 2, 2));
		steps.push_back(tick_row(32'd20000, 32'hFFFF_F000));
		steps.push_back(tick_row(32'd13000, 32'h0000_F000));
		steps.push_back(cfg_row(CFG_PARTICLE_LIFETIME, 32'h0));
		steps.push_back(tick_row(32'd30000, 32'h1234_5678));
		steps.push_back(tick_row(32'h0, 32'h1234_5678));
		steps.push_back(cfg_row(CFG_SPAWN_INTERVAL, 32'h0));
		steps.push_back(tick_row(32'd5, 32'hAAAA_AAAA));
		steps.push_back(cfg_row(CFG_PARTICLE_LIFETIME, 32'hFFFF_FFFF));
		steps.push_back(tick_row(32'd300, 32'h5555_5555));
		steps.push_back(tick_row(32'h0, 32'h5555_5554));
		steps.push_back(cfg_row(CFG_SPAWN_INTERVAL, 32'hFFFF_FFFF));
		steps.push_back(tick_row(32'hFFFF_FFFF, 32'h0));
		steps.push_back(tick_row(32'hFFFF_FFFF, 32'h1));
		steps.push_back(cfg_row(CFG_UNMAPPED_LO, 32'h1234_5678));
		steps.push_back(cfg_row(CFG_UNMAPPED_HI, 32'hFFFF_FFFF));
		steps.push_back(tick_row(32'd1, 32'd2));

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		foreach (steps[i]) begin
			if (steps[i].is_cfg) begin
				write_reg(steps[i].idx, steps[i].data);
			end else begin
				if ($urandom_range(0, 2) == 0)
					idle_input($urandom_range(1, 12));
				send_tick(steps[i].delta, steps[i].now, steps[i].typed, steps[i].res);
			end
		end

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin iv = SPAWN_INTERVAL_RST; lt = PARTICLE_LIFETIME_RST; end
				1: begin iv = 32'd1; lt = 32'h0000_0040; end
				2: begin iv = 32'hFFFF_FFFF; lt = 32'hFFFF_FFFF; end
				3: begin iv = 32'h0; lt = 32'h0; end
				4: begin iv = 32'h0000_4000; lt = 32'h0002_0000; end
				5: begin iv = $urandom_range(1, 32'h1_0000); lt = $urandom_range(0, 32'h8_0000); end
				6: begin iv = $urandom; lt = $urandom; end
				default: begin iv = SPAWN_INTERVAL_RST; lt = PARTICLE_LIFETIME_RST; end
			endcase
			gaps_on = (p % 3 != 1) && (p != 7);
			stall_on = (p % 3 != 2) && (p != 7);
			write_reg(CFG_SPAWN_INTERVAL, iv);
			write_reg(CFG_PARTICLE_LIFETIME, lt);
			step = (iv == '0) ? 64'd1 : 64'(iv);
			for (int k = 0; k < PHASE_TICKS; k++) begin
				if (k == PHASE_TICKS / 2 && p % 2 == 0)
					drain_ring();
				if (gaps_on && $urandom_range(0, 3) == 0)
					idle_input($urandom_range(1, 12));
				sel = $urandom_range(0, 99);
				if (sel < 60)
					wide = step * $urandom_range(0, 6) + $urandom_range(0, 32'(step - 1));
				else if (sel < 80)
					wide = 64'($urandom_range(0, 32'(step)));
				else
					wide = 64'($urandom);
				d = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[TIME_W-1:0];
				if ($urandom_range(0, 99) < 88)
					clock_now = clock_now + d;
				else
					clock_now = $urandom;
				send_tick(d, clock_now, 1'b0, '0);
			end
		end

		drain_ring();
		repeat (64) @(posedge clk);
		if (fault_count == 0 && pending_ticks.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
